// File: design/qwt_pkg.sv
package qwt_pkg;

   localparam int FIELD_JOINTS = 5;
   localparam int POS_W        = 16;
   localparam int DIF_W        = 17;
   localparam int VEL_W        = 24;
   localparam int TIME_W       = 24;
   localparam int CFG_W        = 24;
   localparam int CSR_IDX_W    = 2;
   localparam int OP_W         = 2;
   localparam int FRAC_W       = 16;
   localparam int SQ_W         = 36;
   localparam int ROOT_W       = 18;
   localparam int ROOT_STEPS   = 18;
   localparam int DIV_STEPS    = 16;
   localparam int POW_STEPS    = 4;
   localparam int POLY_STEPS   = 6;
   localparam int STEP_W       = 5;
   localparam int MUL_A_W      = 32;
   localparam int MUL_B_W      = 20;
   localparam int MUL_P_W      = 52;
   localparam int ACC_W        = 46;
   localparam int COEF_X_W     = 27;
   localparam int SAT_W        = 40;
   localparam int DUR_SHIFT    = 12;
   localparam int DUR_W        = 30;
   localparam int TIME_MAX     = 16777215;
   localparam int POS_MAX      = 32767;
   localparam int POS_MIN      = -32768;
   localparam int VEL_MAX      = 8388607;
   localparam int VEL_MIN      = -8388608;

   typedef enum logic [OP_W-1:0] {
      OP_START  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIME_PER_DIST = 2'd0,
      CSR_COEFF_CUBIC   = 2'd1,
      CSR_COEFF_QUARTIC = 2'd2,
      CSR_COEFF_QUINTIC = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_SQ_WAIT,
      ST_ROOT,
      ST_DUR,
      ST_END,
      ST_SRCH,
      ST_DIV,
      ST_POW,
      ST_POLY,
      ST_JNT,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_SQ,
      MUL_DUR,
      MUL_POW,
      MUL_PP,
      MUL_VP,
      MUL_JP,
      MUL_JV
   } mul_tag_type;

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SAT_W-1:0] v);
      if (v > SAT_W'(POS_MAX)) begin
         return POS_W'(POS_MAX);
      end else if (v < SAT_W'(POS_MIN)) begin
         return POS_W'(POS_MIN);
      end else begin
         return v[POS_W-1:0];
      end
   endfunction

   function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [SAT_W-1:0] v);
      if (v > SAT_W'(VEL_MAX)) begin
         return VEL_W'(VEL_MAX);
      end else if (v < SAT_W'(VEL_MIN)) begin
         return VEL_W'(VEL_MIN);
      end else begin
         return v[VEL_W-1:0];
      end
   endfunction

endpackage

// File: design/qwt_if.sv
interface qwt_req_if;
   logic                               valid;
   logic                               ready;
   logic [qwt_pkg::OP_W-1:0]           op;
   logic signed [qwt_pkg::POS_W-1:0]   joint_0;
   logic signed [qwt_pkg::POS_W-1:0]   joint_1;
   logic signed [qwt_pkg::POS_W-1:0]   joint_2;
   logic signed [qwt_pkg::POS_W-1:0]   joint_3;
   logic signed [qwt_pkg::POS_W-1:0]   joint_4;
   logic [qwt_pkg::TIME_W-1:0]         query_time;

   modport source (output valid, op, joint_0, joint_1, joint_2, joint_3, joint_4, query_time,
                   input ready);
   modport sink (input valid, op, joint_0, joint_1, joint_2, joint_3, joint_4, query_time,
                 output ready);
endinterface

interface qwt_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [qwt_pkg::POS_W-1:0]   pos_0;
   logic signed [qwt_pkg::POS_W-1:0]   pos_1;
   logic signed [qwt_pkg::POS_W-1:0]   pos_2;
   logic signed [qwt_pkg::POS_W-1:0]   pos_3;
   logic signed [qwt_pkg::POS_W-1:0]   pos_4;
   logic signed [qwt_pkg::VEL_W-1:0]   vel_0;
   logic signed [qwt_pkg::VEL_W-1:0]   vel_1;
   logic signed [qwt_pkg::VEL_W-1:0]   vel_2;
   logic signed [qwt_pkg::VEL_W-1:0]   vel_3;
   logic signed [qwt_pkg::VEL_W-1:0]   vel_4;
   logic                               finished;

   modport source (output valid, pos_0, pos_1, pos_2, pos_3, pos_4,
                   vel_0, vel_1, vel_2, vel_3, vel_4, finished, input ready);
   modport sink (input valid, pos_0, pos_1, pos_2, pos_3, pos_4,
                 vel_0, vel_1, vel_2, vel_3, vel_4, finished, output ready);
endinterface

// File: design/quintic_waypoint_trajectory.sv
// Waypoint trajectory generator with quintic blending.
// req_chan carries one beat per command: op START loads the start pose and
// clears the path, op APPEND stores a waypoint and extends the end time if
// the store is not full, op QUERY asks for the commanded pose and rate at
// query_time. Only QUERY puts a beat on rsp_chan; the other op codes do not.
// csr_we/csr_index/csr_wdata write the time scale and the three blend
// coefficients; write them only while no command is in flight.
// All arithmetic runs through one shared 32x20 multiplier, one shift-subtract
// root unit and one shift-subtract divider under a small sequencer; req_chan
// is not ready while a command is being worked on.
// Work per command: START none beyond loading; APPEND 18 root steps; QUERY at
// time zero, with no waypoints or past the end no arithmetic; other QUERY a
// segment search one entry a cycle, 16 divide steps, 4 powers, 6 polynomial
// terms and 2 products per joint.
// The result sits in an output register, so a new command is taken while
// rsp_chan is stalled; a second query then waits at its end for that slot.
// Synchronous reset clears the path, the start pose and the output valid
// and restores the register defaults.
module quintic_waypoint_trajectory #(
   parameter int MAX_WAYPOINTS = 16,
   parameter int NUM_JOINTS    = 5
) (
   input  logic                               clock,
   input  logic                               reset,
   qwt_req_if.sink                            req_chan,
   qwt_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [qwt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [qwt_pkg::CFG_W-1:0]          csr_wdata
);

   localparam int AW        = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
   localparam int CW        = $clog2(MAX_WAYPOINTS + 1);
   localparam int JIW       = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam int PW        = NUM_JOINTS * qwt_pkg::POS_W;
   localparam int JNT_STEPS = 2 * NUM_JOINTS;
   localparam logic [5:0] ROOT_TOP = 6'(qwt_pkg::SQ_W - 2);

   qwt_pkg::state_type   state_ff, state_in;
   qwt_pkg::mul_tag_type mul_tag, tag_ff;
   qwt_pkg::op_type      req_op;

   logic [qwt_pkg::STEP_W-1:0]          step_ff, tidx_ff;
   logic [qwt_pkg::TIME_W-1:0]          tpd_ff;
   logic signed [qwt_pkg::CFG_W-1:0]    c3_ff, c4_ff, c5_ff;
   logic signed [qwt_pkg::POS_W-1:0]    start_ff [NUM_JOINTS];
   logic signed [qwt_pkg::POS_W-1:0]    last_ff  [NUM_JOINTS];
   logic signed [qwt_pkg::POS_W-1:0]    nw_ff    [NUM_JOINTS];
   logic signed [qwt_pkg::POS_W-1:0]    pa_ff    [NUM_JOINTS];
   logic signed [qwt_pkg::POS_W-1:0]    pb_ff    [NUM_JOINTS];
   logic signed [qwt_pkg::POS_W-1:0]    wpos_ff  [NUM_JOINTS];
   logic signed [qwt_pkg::VEL_W-1:0]    wvel_ff  [NUM_JOINTS];
   logic signed [qwt_pkg::POS_W-1:0]    opos_ff  [NUM_JOINTS];
   logic signed [qwt_pkg::VEL_W-1:0]    ovel_ff  [NUM_JOINTS];
   logic                                wfin_ff, ofin_ff, ovld_ff;
   logic [CW-1:0]                       count_ff, saddr_ff, seg_ff;
   logic [qwt_pkg::TIME_W-1:0]          run_ff, t_ff, prev_end_ff, span_ff, rem_ff;
   logic                                svld_ff;
   logic [qwt_pkg::FRAC_W-1:0]          s_ff;
   logic [qwt_pkg::FRAC_W-1:0]          pw_ff [qwt_pkg::POW_STEPS];
   logic signed [qwt_pkg::ACC_W-1:0]    pp_ff, vp_ff;
   logic [qwt_pkg::SQ_W-1:0]            sq_ff, rr_ff;
   logic signed [qwt_pkg::MUL_P_W-1:0]  prod_ff;

   logic [PW-1:0]                       wp_mem [MAX_WAYPOINTS];
   logic [qwt_pkg::TIME_W-1:0]          end_mem [MAX_WAYPOINTS];
   logic [PW-1:0]                       wp_rd_ff;
   logic [qwt_pkg::TIME_W-1:0]          end_rd_ff;
   logic [AW-1:0]                       wp_raddr, end_raddr;
   logic                                wp_we;

   logic signed [qwt_pkg::POS_W-1:0]    in_field [qwt_pkg::FIELD_JOINTS];
   logic signed [qwt_pkg::POS_W-1:0]    in_pose  [NUM_JOINTS];
   logic signed [qwt_pkg::POS_W-1:0]    rd_pose  [NUM_JOINTS];
   logic [PW-1:0]                       in_pack;

   logic signed [qwt_pkg::MUL_A_W-1:0]  mul_a;
   logic signed [qwt_pkg::MUL_B_W-1:0]  mul_b;
   logic                                req_acc, full, early, deliver;
   logic [JIW-1:0]                      jsel, sqsel, tsel;
   logic signed [qwt_pkg::DIF_W-1:0]    d_sq, d_jnt;
   logic signed [qwt_pkg::COEF_X_W-1:0] c3x, c4x, c5x;
   logic signed [qwt_pkg::MUL_A_W-1:0]  pp_sh, vp_sh;
   logic signed [qwt_pkg::SAT_W-1:0]    prod_sh, pos_sum;
   logic [qwt_pkg::SQ_W-1:0]            rbit;
   logic [qwt_pkg::SQ_W:0]              rsum;
   logic                                rge;
   logic [qwt_pkg::TIME_W:0]            rem2;
   logic                                dge;
   logic [qwt_pkg::DUR_W-1:0]           dur;
   logic [qwt_pkg::DUR_W:0]             esum;
   logic [qwt_pkg::TIME_W-1:0]          end_val;

   assign in_field[0] = req_chan.joint_0;
   assign in_field[1] = req_chan.joint_1;
   assign in_field[2] = req_chan.joint_2;
   assign in_field[3] = req_chan.joint_3;
   assign in_field[4] = req_chan.joint_4;

   for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_pose
      if (j < qwt_pkg::FIELD_JOINTS) begin : g_in
         assign in_pose[j] = in_field[j];
      end else begin : g_zero
         assign in_pose[j] = '0;
      end
      assign in_pack[j*qwt_pkg::POS_W +: qwt_pkg::POS_W] = in_pose[j];
      assign rd_pose[j] = wp_rd_ff[j*qwt_pkg::POS_W +: qwt_pkg::POS_W];
   end

   assign req_op   = qwt_pkg::op_type'(req_chan.op);
   assign req_acc  = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == qwt_pkg::ST_IDLE);
   assign full     = (count_ff == CW'(MAX_WAYPOINTS));
   assign early    = (req_chan.query_time == '0) || (count_ff == '0) ||
                     (req_chan.query_time >= run_ff);
   assign deliver  = (state_ff == qwt_pkg::ST_DONE) && (!ovld_ff || rsp_chan.ready);
   assign wp_we    = (state_ff == qwt_pkg::ST_IDLE) && req_acc &&
                     (req_op == qwt_pkg::OP_APPEND) && !full;

   assign jsel  = step_ff[JIW:1];
   assign sqsel = step_ff[JIW-1:0];
   assign tsel  = tidx_ff[JIW:1];
   assign d_sq  = qwt_pkg::DIF_W'(nw_ff[sqsel]) - qwt_pkg::DIF_W'(last_ff[sqsel]);
   assign d_jnt = qwt_pkg::DIF_W'(pb_ff[jsel]) - qwt_pkg::DIF_W'(pa_ff[jsel]);

   assign c3x = (qwt_pkg::COEF_X_W'(c3_ff) <<< 1) + qwt_pkg::COEF_X_W'(c3_ff);
   assign c4x = qwt_pkg::COEF_X_W'(c4_ff) <<< 2;
   assign c5x = (qwt_pkg::COEF_X_W'(c5_ff) <<< 2) + qwt_pkg::COEF_X_W'(c5_ff);

   assign pp_sh   = qwt_pkg::MUL_A_W'(pp_ff >>> qwt_pkg::FRAC_W);
   assign vp_sh   = qwt_pkg::MUL_A_W'(vp_ff >>> qwt_pkg::FRAC_W);
   assign prod_sh = qwt_pkg::SAT_W'(prod_ff >>> qwt_pkg::FRAC_W);
   assign pos_sum = qwt_pkg::SAT_W'(pa_ff[tsel]) + prod_sh;

   assign rbit = qwt_pkg::SQ_W'(1) << (ROOT_TOP - {step_ff, 1'b0});
   assign rsum = (qwt_pkg::SQ_W + 1)'(rr_ff) + (qwt_pkg::SQ_W + 1)'(rbit);
   assign rge  = (qwt_pkg::SQ_W + 1)'(sq_ff) >= rsum;

   assign rem2 = {rem_ff, 1'b0};
   assign dge  = rem2 >= {1'b0, span_ff};

   assign dur     = prod_ff[qwt_pkg::DUR_SHIFT +: qwt_pkg::DUR_W];
   assign esum    = (qwt_pkg::DUR_W + 1)'(dur) + (qwt_pkg::DUR_W + 1)'(run_ff);
   assign end_val = (esum > (qwt_pkg::DUR_W + 1)'(qwt_pkg::TIME_MAX)) ?
                    qwt_pkg::TIME_W'(qwt_pkg::TIME_MAX) : esum[qwt_pkg::TIME_W-1:0];

   assign end_raddr = saddr_ff[AW-1:0];
   assign wp_raddr  = ((state_ff == qwt_pkg::ST_DIV) && (step_ff == '0) && (seg_ff != '0)) ?
                      AW'(seg_ff - CW'(1)) : seg_ff[AW-1:0];

   always_comb begin
      state_in = state_ff;
      mul_a    = '0;
      mul_b    = '0;
      mul_tag  = qwt_pkg::MUL_NONE;
      unique case (state_ff)
         qwt_pkg::ST_IDLE: begin
            if (req_acc) begin
               unique case (req_op)
                  qwt_pkg::OP_START: state_in = qwt_pkg::ST_IDLE;
                  qwt_pkg::OP_APPEND: begin
                     if (!full) begin
                        state_in = qwt_pkg::ST_SQ;
                     end
                  end
                  qwt_pkg::OP_QUERY: state_in = early ? qwt_pkg::ST_DONE : qwt_pkg::ST_SRCH;
                  default: state_in = qwt_pkg::ST_IDLE;
               endcase
            end
         end
         qwt_pkg::ST_SQ: begin
            mul_a   = qwt_pkg::MUL_A_W'(d_sq);
            mul_b   = qwt_pkg::MUL_B_W'(d_sq);
            mul_tag = qwt_pkg::MUL_SQ;
            if (step_ff == qwt_pkg::STEP_W'(NUM_JOINTS - 1)) begin
               state_in = qwt_pkg::ST_SQ_WAIT;
            end
         end
         qwt_pkg::ST_SQ_WAIT: state_in = qwt_pkg::ST_ROOT;
         qwt_pkg::ST_ROOT: begin
            if (step_ff == qwt_pkg::STEP_W'(qwt_pkg::ROOT_STEPS - 1)) begin
               state_in = qwt_pkg::ST_DUR;
            end
         end
         qwt_pkg::ST_DUR: begin
            mul_a    = qwt_pkg::MUL_A_W'(tpd_ff);
            mul_b    = qwt_pkg::MUL_B_W'(rr_ff[qwt_pkg::ROOT_W-1:0]);
            mul_tag  = qwt_pkg::MUL_DUR;
            state_in = qwt_pkg::ST_END;
         end
         qwt_pkg::ST_END: state_in = qwt_pkg::ST_IDLE;
         qwt_pkg::ST_SRCH: begin
            if (svld_ff) begin
               if (t_ff < end_rd_ff) begin
                  state_in = qwt_pkg::ST_DIV;
               end else if (saddr_ff == count_ff) begin
                  state_in = qwt_pkg::ST_DONE;
               end
            end
         end
         qwt_pkg::ST_DIV: begin
            if (step_ff == qwt_pkg::STEP_W'(qwt_pkg::DIV_STEPS - 1)) begin
               state_in = qwt_pkg::ST_POW;
            end
         end
         qwt_pkg::ST_POW: begin
            mul_a   = (step_ff == '0) ? qwt_pkg::MUL_A_W'(s_ff) :
                      qwt_pkg::MUL_A_W'(prod_ff[2*qwt_pkg::FRAC_W-1:qwt_pkg::FRAC_W]);
            mul_b   = qwt_pkg::MUL_B_W'(s_ff);
            mul_tag = qwt_pkg::MUL_POW;
            if (step_ff == qwt_pkg::STEP_W'(qwt_pkg::POW_STEPS - 1)) begin
               state_in = qwt_pkg::ST_POLY;
            end
         end
         qwt_pkg::ST_POLY: begin
            unique case (step_ff)
               qwt_pkg::STEP_W'(0): begin
                  mul_a = qwt_pkg::MUL_A_W'(c3_ff);
                  mul_b = qwt_pkg::MUL_B_W'(pw_ff[1]);
               end
               qwt_pkg::STEP_W'(1): begin
                  mul_a = qwt_pkg::MUL_A_W'(c4_ff);
                  mul_b = qwt_pkg::MUL_B_W'(pw_ff[2]);
               end
               qwt_pkg::STEP_W'(2): begin
                  mul_a = qwt_pkg::MUL_A_W'(c5_ff);
                  mul_b = qwt_pkg::MUL_B_W'(pw_ff[3]);
               end
               qwt_pkg::STEP_W'(3): begin
                  mul_a = qwt_pkg::MUL_A_W'(c3x);
                  mul_b = qwt_pkg::MUL_B_W'(pw_ff[0]);
               end
               qwt_pkg::STEP_W'(4): begin
                  mul_a = qwt_pkg::MUL_A_W'(c4x);
                  mul_b = qwt_pkg::MUL_B_W'(pw_ff[1]);
               end
               default: begin
                  mul_a = qwt_pkg::MUL_A_W'(c5x);
                  mul_b = qwt_pkg::MUL_B_W'(pw_ff[2]);
               end
            endcase
            mul_tag = (step_ff < qwt_pkg::STEP_W'(3)) ? qwt_pkg::MUL_PP : qwt_pkg::MUL_VP;
            if (step_ff == qwt_pkg::STEP_W'(qwt_pkg::POLY_STEPS - 1)) begin
               state_in = qwt_pkg::ST_JNT;
            end
         end
         qwt_pkg::ST_JNT: begin
            mul_a   = step_ff[0] ? vp_sh : pp_sh;
            mul_b   = qwt_pkg::MUL_B_W'(d_jnt);
            mul_tag = step_ff[0] ? qwt_pkg::MUL_JV : qwt_pkg::MUL_JP;
            if (step_ff == qwt_pkg::STEP_W'(JNT_STEPS - 1)) begin
               state_in = qwt_pkg::ST_DRAIN;
            end
         end
         qwt_pkg::ST_DRAIN: state_in = qwt_pkg::ST_DONE;
         qwt_pkg::ST_DONE: begin
            if (deliver) begin
               state_in = qwt_pkg::ST_IDLE;
            end
         end
         default: state_in = qwt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qwt_pkg::ST_IDLE;
         tag_ff   <= qwt_pkg::MUL_NONE;
         count_ff <= '0;
         run_ff   <= '0;
         ovld_ff  <= 1'b0;
         tpd_ff   <= qwt_pkg::TIME_W'(65536);
         c3_ff    <= qwt_pkg::CFG_W'(655360);
         c4_ff    <= qwt_pkg::CFG_W'(-983040);
         c5_ff    <= qwt_pkg::CFG_W'(393216);
         for (int j = 0; j < NUM_JOINTS; j++) begin
            start_ff[j] <= '0;
            last_ff[j]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         tag_ff   <= mul_tag;
         if (csr_we) begin
            unique case (qwt_pkg::csr_idx_type'(csr_index))
               qwt_pkg::CSR_TIME_PER_DIST: tpd_ff <= csr_wdata;
               qwt_pkg::CSR_COEFF_CUBIC:   c3_ff  <= csr_wdata;
               qwt_pkg::CSR_COEFF_QUARTIC: c4_ff  <= csr_wdata;
               qwt_pkg::CSR_COEFF_QUINTIC: c5_ff  <= csr_wdata;
            endcase
         end
         if ((state_ff == qwt_pkg::ST_IDLE) && req_acc && (req_op == qwt_pkg::OP_START)) begin
            count_ff <= '0;
            run_ff   <= '0;
            for (int j = 0; j < NUM_JOINTS; j++) begin
               start_ff[j] <= in_pose[j];
               last_ff[j]  <= in_pose[j];
            end
         end
         if (state_ff == qwt_pkg::ST_END) begin
            run_ff   <= end_val;
            count_ff <= count_ff + CW'(1);
            for (int j = 0; j < NUM_JOINTS; j++) begin
               last_ff[j] <= nw_ff[j];
            end
         end
         if (deliver) begin
            ovld_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            ovld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= (state_in != state_ff) ? '0 : step_ff + qwt_pkg::STEP_W'(1);
      tidx_ff   <= step_ff;
      prod_ff   <= mul_a * mul_b;
      wp_rd_ff  <= wp_mem[wp_raddr];
      end_rd_ff <= end_mem[end_raddr];
      if (wp_we) begin
         wp_mem[count_ff[AW-1:0]] <= in_pack;
      end
      if (state_ff == qwt_pkg::ST_END) begin
         end_mem[count_ff[AW-1:0]] <= end_val;
      end

      if ((state_ff == qwt_pkg::ST_IDLE) && req_acc) begin
         t_ff        <= req_chan.query_time;
         sq_ff       <= '0;
         rr_ff       <= '0;
         saddr_ff    <= '0;
         svld_ff     <= 1'b0;
         prev_end_ff <= '0;
         wfin_ff     <= (req_chan.query_time != '0);
         for (int j = 0; j < NUM_JOINTS; j++) begin
            nw_ff[j]   <= in_pose[j];
            wvel_ff[j] <= '0;
            wpos_ff[j] <= ((req_chan.query_time != '0) && (count_ff != '0)) ?
                          last_ff[j] : start_ff[j];
         end
      end

      if (state_ff == qwt_pkg::ST_ROOT) begin
         if (rge) begin
            sq_ff <= sq_ff - rsum[qwt_pkg::SQ_W-1:0];
            rr_ff <= (rr_ff >> 1) + rbit;
         end else begin
            rr_ff <= rr_ff >> 1;
         end
      end else if (tag_ff == qwt_pkg::MUL_SQ) begin
         sq_ff <= sq_ff + prod_ff[qwt_pkg::SQ_W-1:0];
      end

      if (state_ff == qwt_pkg::ST_SRCH) begin
         saddr_ff <= saddr_ff + CW'(1);
         svld_ff  <= 1'b1;
         if (svld_ff) begin
            if (t_ff < end_rd_ff) begin
               seg_ff  <= saddr_ff - CW'(1);
               span_ff <= end_rd_ff - prev_end_ff;
               rem_ff  <= t_ff - prev_end_ff;
               wfin_ff <= 1'b0;
            end else begin
               prev_end_ff <= end_rd_ff;
               if (saddr_ff == count_ff) begin
                  wfin_ff <= 1'b0;
                  for (int j = 0; j < NUM_JOINTS; j++) begin
                     wpos_ff[j] <= start_ff[j];
                  end
               end
            end
         end
      end

      if (state_ff == qwt_pkg::ST_DIV) begin
         rem_ff <= dge ? qwt_pkg::TIME_W'(rem2 - {1'b0, span_ff}) : rem2[qwt_pkg::TIME_W-1:0];
         s_ff   <= {s_ff[qwt_pkg::FRAC_W-2:0], dge};
         if (step_ff == qwt_pkg::STEP_W'(1)) begin
            for (int j = 0; j < NUM_JOINTS; j++) begin
               pa_ff[j] <= (seg_ff == '0) ? start_ff[j] : rd_pose[j];
            end
         end
         if (step_ff == qwt_pkg::STEP_W'(2)) begin
            for (int j = 0; j < NUM_JOINTS; j++) begin
               pb_ff[j] <= rd_pose[j];
            end
         end
      end

      if (tag_ff == qwt_pkg::MUL_POW) begin
         pw_ff[tidx_ff[1:0]] <= prod_ff[2*qwt_pkg::FRAC_W-1:qwt_pkg::FRAC_W];
      end

      if (state_ff == qwt_pkg::ST_DIV) begin
         pp_ff <= '0;
         vp_ff <= '0;
      end else if (tag_ff == qwt_pkg::MUL_PP) begin
         pp_ff <= pp_ff + qwt_pkg::ACC_W'(prod_ff);
      end else if (tag_ff == qwt_pkg::MUL_VP) begin
         vp_ff <= vp_ff + qwt_pkg::ACC_W'(prod_ff);
      end

      if (tag_ff == qwt_pkg::MUL_JP) begin
         wpos_ff[tsel] <= qwt_pkg::sat_pos(pos_sum);
      end else if (tag_ff == qwt_pkg::MUL_JV) begin
         wvel_ff[tsel] <= qwt_pkg::sat_vel(prod_sh);
      end

      if (deliver) begin
         ofin_ff <= wfin_ff;
         for (int j = 0; j < NUM_JOINTS; j++) begin
            opos_ff[j] <= wpos_ff[j];
            ovel_ff[j] <= wvel_ff[j];
         end
      end
   end

   logic signed [qwt_pkg::POS_W-1:0] rsp_pos [qwt_pkg::FIELD_JOINTS];
   logic signed [qwt_pkg::VEL_W-1:0] rsp_vel [qwt_pkg::FIELD_JOINTS];

   for (genvar f = 0; f < qwt_pkg::FIELD_JOINTS; f++) begin : g_rsp
      if (f < NUM_JOINTS) begin : g_used
         assign rsp_pos[f] = opos_ff[f];
         assign rsp_vel[f] = ovel_ff[f];
      end else begin : g_zero
         assign rsp_pos[f] = '0;
         assign rsp_vel[f] = '0;
      end
   end

   assign rsp_chan.valid    = ovld_ff;
   assign rsp_chan.finished = ofin_ff;
   assign rsp_chan.pos_0    = rsp_pos[0];
   assign rsp_chan.pos_1    = rsp_pos[1];
   assign rsp_chan.pos_2    = rsp_pos[2];
   assign rsp_chan.pos_3    = rsp_pos[3];
   assign rsp_chan.pos_4    = rsp_pos[4];
   assign rsp_chan.vel_0    = rsp_vel[0];
   assign rsp_chan.vel_1    = rsp_vel[1];
   assign rsp_chan.vel_2    = rsp_vel[2];
   assign rsp_chan.vel_3    = rsp_vel[3];
   assign rsp_chan.vel_4    = rsp_vel[4];

   ap_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_WAYPOINTS))
      else $error("waypoint count past capacity");

   ap_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == qwt_pkg::ST_DIV) |-> (rem_ff < span_ff))
      else $error("divider remainder not below span");

   ap_end_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == qwt_pkg::ST_END) |=> (run_ff >= $past(run_ff)))
      else $error("end time went backward on append");

   ap_beat_src: assert property (@(posedge clock) disable iff (reset)
      $rose(ovld_ff) |-> $past(state_ff == qwt_pkg::ST_DONE))
      else $error("result beat without a finished query");

endmodule

// File: verif/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import qwt_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int NJ = 5;
   localparam int WP_DEPTH = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 120;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic [OP_W-1:0]         op;
      logic signed [POS_W-1:0] jnt [NJ];
      logic [TIME_W-1:0]       qtime;
   } cmd_t;

   typedef struct {
      logic signed [POS_W-1:0] pos [NJ];
      logic signed [VEL_W-1:0] vel [NJ];
      logic                    fin;
   } setpoint_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   qwt_req_if req_chan();
   qwt_rsp_if rsp_chan();

   quintic_waypoint_trajectory dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   cmd_t      cmd_queue [$];
   setpoint_t setpoint_queue [$];
   int  tx_idle_pct = 0;
   int  rx_idle_pct = 0;
   bit  hold_request = 0;
   int  hold_left = 0;
   bit  hold_done = 0;
   bit  beat_taken = 0;
   int  errors = 0;
   int  queries_seen = 0;
   int  cmds_sent = 0;
   int  quiet_cycles = 0;

   longint start_pose [NJ];
   longint waypoints [WP_DEPTH][NJ];
   longint seg_end [WP_DEPTH];
   int     wp_count;
   longint path_end;
   longint time_per_dist;
   longint c3, c4, c5;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint clamp(longint v, int w);
      longint hi = (64'sd1 <<< (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic void apply_cmd(cmd_t c);
      setpoint_t sp;
      longint unsigned sq, root, dur, t, seg_start, span;
      longint d, s, s2, s3, s4, s5, pp, vp, e;
      int i;
      bit found;
      case (c.op)
         OP_START: begin
            foreach (start_pose[j]) start_pose[j] = c.jnt[j];
            wp_count = 0;
            path_end = 0;
         end
         OP_APPEND: begin
            if (wp_count < WP_DEPTH) begin
               sq = 0;
               for (int j = 0; j < NJ; j++) begin
                  waypoints[wp_count][j] = c.jnt[j];
                  d = c.jnt[j] - (wp_count ? waypoints[wp_count-1][j] : start_pose[j]);
                  sq += d * d;
               end
               root = int_sqrt(sq);
               dur = (root * time_per_dist) >> 12;
               e = path_end + dur;
               if (e > TIME_MAX) e = TIME_MAX;
               path_end = e;
               seg_end[wp_count] = e;
               wp_count++;
            end
         end
         OP_QUERY: begin
            t = c.qtime;
            for (int j = 0; j < NJ; j++) begin
               sp.pos[j] = start_pose[j];
               sp.vel[j] = '0;
            end
            sp.fin = 1'b0;
            if (t == 0) begin
            end else if (wp_count == 0) begin
               sp.fin = 1'b1;
            end else if (t >= path_end) begin
               for (int j = 0; j < NJ; j++) sp.pos[j] = waypoints[wp_count-1][j];
               sp.fin = 1'b1;
            end else begin
               seg_start = 0;
               found = 0;
               for (i = 0; i < wp_count; i++) begin
                  if (t >= seg_start && t < seg_end[i]) begin
                     found = 1;
                     break;
                  end
                  seg_start = seg_end[i];
               end
               if (found) begin
                  span = seg_end[i] - seg_start;
                  s = ((t - seg_start) << 16) / span;
                  s2 = (s * s) >>> 16;
                  s3 = (s2 * s) >>> 16;
                  s4 = (s3 * s) >>> 16;
                  s5 = (s4 * s) >>> 16;
                  pp = (c3 * s3 + c4 * s4 + c5 * s5) >>> 16;
                  vp = (3 * c3 * s2 + 4 * c4 * s3 + 5 * c5 * s4) >>> 16;
                  for (int j = 0; j < NJ; j++) begin
                     e = i ? waypoints[i-1][j] : start_pose[j];
                     d = waypoints[i][j] - e;
                     sp.pos[j] = clamp(e + ((pp * d) >>> 16), POS_W);
                     sp.vel[j] = clamp((vp * d) >>> 16, VEL_W);
                  end
               end
            end
            setpoint_queue.push_back(sp);
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      beat_taken = 0;
      if (!reset && req_chan.valid && req_chan.ready) begin
         apply_cmd(cmd_queue.pop_front());
         beat_taken = 1;
         cmds_sent++;
      end
   end

   always @(negedge clock) begin
      cmd_t c;
      if (reset || (req_chan.valid && !beat_taken)) begin
      end else if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
         c = cmd_queue[0];
         req_chan.valid <= 1'b1;
         req_chan.op <= c.op;
         req_chan.joint_0 <= c.jnt[0];
         req_chan.joint_1 <= c.jnt[1];
         req_chan.joint_2 <= c.jnt[2];
         req_chan.joint_3 <= c.jnt[3];
         req_chan.joint_4 <= c.jnt[4];
         req_chan.query_time <= c.qtime;
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (hold_request && !hold_done && hold_left == 0) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      setpoint_t want;
      logic signed [POS_W-1:0] got_pos [NJ];
      logic signed [VEL_W-1:0] got_vel [NJ];
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got_pos = '{rsp_chan.pos_0, rsp_chan.pos_1, rsp_chan.pos_2, rsp_chan.pos_3,
                     rsp_chan.pos_4};
         got_vel = '{rsp_chan.vel_0, rsp_chan.vel_1, rsp_chan.vel_2, rsp_chan.vel_3,
                     rsp_chan.vel_4};
         queries_seen++;
         if (setpoint_queue.size() == 0) begin
            $display("%0t unexpected setpoint beat: pos_0 %0d", $realtime, got_pos[0]);
            errors++;
         end else begin
            want = setpoint_queue.pop_front();
            for (int j = 0; j < NJ; j++) begin
               if (got_pos[j] !== want.pos[j]) begin
                  $display("%0t pos_%0d expected %0d actual %0d", $realtime, j, want.pos[j],
                           got_pos[j]);
                  errors++;
               end
               if (got_vel[j] !== want.vel[j]) begin
                  $display("%0t vel_%0d expected %0d actual %0d", $realtime, j, want.vel[j],
                           got_vel[j]);
                  errors++;
               end
            end
            if (rsp_chan.finished !== want.fin) begin
               $display("%0t finished expected %0b actual %0b", $realtime, want.fin,
                        rsp_chan.finished);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || beat_taken || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic cmd_t make_cmd(logic [OP_W-1:0] op, int spread, logic [TIME_W-1:0] qt);
      cmd_t c;
      c.op = op;
      for (int j = 0; j < NJ; j++) c.jnt[j] = $urandom_range(0, 2 * spread) - spread;
      c.qtime = qt;
      return c;
   endfunction

   function automatic cmd_t pose_cmd(logic [OP_W-1:0] op, logic signed [POS_W-1:0] v);
      cmd_t c;
      c.op = op;
      foreach (c.jnt[j]) c.jnt[j] = v;
      c.qtime = '0;
      return c;
   endfunction

   function automatic cmd_t query_cmd(logic [TIME_W-1:0] qt);
      cmd_t c = make_cmd(OP_QUERY, 32767, qt);
      return c;
   endfunction

   task automatic write_reg(csr_idx_type idx, logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_TIME_PER_DIST: time_per_dist = value;
         CSR_COEFF_CUBIC:   c3 = longint'(signed'(value));
         CSR_COEFF_QUARTIC: c4 = longint'(signed'(value));
         default:           c5 = longint'(signed'(value));
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain;
      wait (cmd_queue.size() == 0 && setpoint_queue.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random(int count, int shadow_end_scale);
      int n = 0;
      int spread;
      int legs;
      longint est_end;
      while (n < count) begin
         if ($urandom_range(0, 9) == 0) begin
            cmd_queue.push_back(make_cmd($urandom_range(0, 3), 32767, $urandom()));
            n++;
            continue;
         end
         spread = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(16, 4096);
         legs = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 19) : $urandom_range(0, 5);
         cmd_queue.push_back(make_cmd(OP_START, spread, $urandom()));
         for (int k = 0; k < legs; k++) begin
            cmd_queue.push_back(make_cmd(OP_APPEND, spread, $urandom()));
         end
         est_end = longint'(legs) * spread * 2 * shadow_end_scale;
         if (est_end > TIME_MAX) est_end = TIME_MAX;
         repeat ($urandom_range(2, 6)) begin
            cmd_queue.push_back(query_cmd($urandom_range(0, 9) == 0 ? $urandom() :
                                          $urandom_range(1, est_end + 2)));
         end
         n += legs + 5;
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.op = OP_START;
      req_chan.joint_0 = '0;
      req_chan.joint_1 = '0;
      req_chan.joint_2 = '0;
      req_chan.joint_3 = '0;
      req_chan.joint_4 = '0;
      req_chan.query_time = '0;
      rsp_chan.ready = 1'b0;
      foreach (start_pose[j]) start_pose[j] = 0;
      wp_count = 0;
      path_end = 0;
      time_per_dist = 65536;
      c3 = 655360;
      c4 = -983040;
      c5 = 393216;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      tx_idle_pct = 36;
      rx_idle_pct = 62;
      cmd_queue.push_back(query_cmd(24'd0));
      cmd_queue.push_back(query_cmd(24'd5));
      cmd_queue.push_back(pose_cmd(OP_START, 16'sh7FFF));
      cmd_queue.push_back(pose_cmd(OP_APPEND, 16'sh8000));
      cmd_queue.push_back(pose_cmd(OP_APPEND, 16'sh7FFF));
      cmd_queue.push_back(query_cmd(24'd1));
      cmd_queue.push_back(query_cmd(24'd300000));
      cmd_queue.push_back(query_cmd(24'hFFFFFF));
      cmd_queue.push_back(make_cmd(OP_UNUSED, 32767, 24'hFFFFFF));
      cmd_queue.push_back(pose_cmd(OP_START, 16'sh0000));
      cmd_queue.push_back(pose_cmd(OP_APPEND, 16'sh1000));
      cmd_queue.push_back(pose_cmd(OP_APPEND, 16'shF000));
      cmd_queue.push_back(query_cmd(24'd100000));
      cmd_queue.push_back(query_cmd(24'd200000));
      cmd_queue.push_back(query_cmd(24'd400000));
      cmd_queue.push_back(query_cmd(24'd600000));
      cmd_queue.push_back(pose_cmd(OP_START, 16'sh8000));
      cmd_queue.push_back(pose_cmd(OP_APPEND, 16'sh8000));
      cmd_queue.push_back(query_cmd(24'd1));
      queue_random(40, 16);
      hold_request = 1;
      queue_random(60, 16);
      drain();

      write_reg(CSR_TIME_PER_DIST, 24'hFFFFFF);
      write_reg(CSR_COEFF_CUBIC, 24'h7FFFFF);
      write_reg(CSR_COEFF_QUARTIC, 24'h800000);
      write_reg(CSR_COEFF_QUINTIC, 24'h7FFFFF);
      tx_idle_pct = 62;
      rx_idle_pct = 36;
      queue_random(100, 4096);
      drain();

      write_reg(CSR_TIME_PER_DIST, 24'd0);
      write_reg(CSR_COEFF_CUBIC, $urandom());
      write_reg(CSR_COEFF_QUARTIC, $urandom());
      write_reg(CSR_COEFF_QUINTIC, $urandom());
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      queue_random(20, 1);
      drain();

      write_reg(CSR_TIME_PER_DIST, $urandom_range(1, 24'hFFFFFF));
      write_reg(CSR_COEFF_CUBIC, 24'h800000);
      write_reg(CSR_COEFF_QUARTIC, 24'h7FFFFF);
      write_reg(CSR_COEFF_QUINTIC, 24'h800000);
      queue_random(60, 256);
      drain();

      write_reg(CSR_TIME_PER_DIST, 24'd4096);
      write_reg(CSR_COEFF_CUBIC, 24'd655360);
      write_reg(CSR_COEFF_QUARTIC, -24'sd983040);
      write_reg(CSR_COEFF_QUINTIC, 24'd393216);
      queue_random(100, 1);
      drain();

      $display("covered %0d commands and %0d setpoint queries over five register settings",
               cmds_sent, queries_seen);
      $display("including a long output stall, full waypoint stores and unused op codes");
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
